// ===== rtl/core/vertex_dedup_indexer_core_macros.svh =====
// assertion macros for the vertex dedup indexer
`ifndef VERTEX_DEDUP_INDEXER_CORE_MACROS_SVH
`define VERTEX_DEDUP_INDEXER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define VDI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define VDI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define VDI_ASSERT_IMPL(label, clk, rst, ante, cons)
`define VDI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/vdi_pkg.sv =====
// shared types and constants for the vertex dedup indexer
package vdi_pkg;
   localparam int TableDepth = 256;
   localparam int AddrWidth  = $clog2(TableDepth);
   localparam int CountWidth = $clog2(TableDepth + 1);
   localparam int CoordWidth = 32;
   localparam int PosWidth   = 3 * CoordWidth;
   localparam int IndexWidth = 8;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_COMPARE, ST_DECIDE, ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic [CoordWidth-1:0] pos_x_bits;
      logic [CoordWidth-1:0] pos_y_bits;
      logic [CoordWidth-1:0] pos_z_bits;
      logic                  mesh_start;
   } req_type;

   typedef struct packed {
      logic [IndexWidth-1:0] vertex_index;
      logic                  was_new;
      logic                  table_full;
   } rsp_type;

   // float equality on raw bits: +0 == -0, nan never equal
   function automatic logic coord_equal(logic [CoordWidth-1:0] a, logic [CoordWidth-1:0] b);
      logic nan_a;
      logic nan_b;
      nan_a = (a[CoordWidth-2:0] > 31'h7F80_0000);
      nan_b = (b[CoordWidth-2:0] > 31'h7F80_0000);
      if (nan_a || nan_b) begin
         return 1'b0;
      end
      if ((a[CoordWidth-2:0] | b[CoordWidth-2:0]) == '0) begin
         return 1'b1;
      end
      return (a == b);
   endfunction
endpackage

// ===== rtl/core/vdi_stream_if.sv =====
// valid/ready channel interface
interface vdi_req_if;
   logic             valid;
   logic             ready;
   vdi_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface vdi_rsp_if;
   logic             valid;
   logic             ready;
   vdi_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/vertex_dedup_indexer_core.sv =====
// top level of the vertex dedup indexer
// One vertex per beat; the block scans stored positions through a single
// table read port and one shared three-coordinate comparator, one entry per
// cycle. Each item is checked against every stored entry of the 256-entry table,
// and the next item is accepted once the result beat has been taken. Reset
// needs no clearing pass: only entries below the fill count are read.
`include "vertex_dedup_indexer_core_macros.svh"
module vertex_dedup_indexer_core (
   input logic         clock,
   input logic         reset,
   vdi_req_if.sink     req,
   vdi_rsp_if.source   rsp
);
   localparam int AW = vdi_pkg::AddrWidth;
   localparam int CW = vdi_pkg::CountWidth;

   vdi_pkg::state_type state_ff, state_in;
   vdi_pkg::req_type   item_ff, item_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic [AW-1:0]      hit_ff, hit_in;
   logic               found_ff, found_in;
   vdi_pkg::rsp_type   out_ff, out_in;
   logic [vdi_pkg::PosWidth-1:0] table_mem [vdi_pkg::TableDepth];
   logic [vdi_pkg::PosWidth-1:0] rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic               match;
   logic [AW-1:0]      cmp_addr_ff;

   // table memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[count_ff[AW-1:0]] <= {item_ff.pos_x_bits, item_ff.pos_y_bits,
                                         item_ff.pos_z_bits};
      end
      rd_data_ff  <= table_mem[rd_addr];
      cmp_addr_ff <= rd_addr;
   end

   // shared comparator
   assign match = vdi_pkg::coord_equal(rd_data_ff[95:64], item_ff.pos_x_bits)
                & vdi_pkg::coord_equal(rd_data_ff[63:32], item_ff.pos_y_bits)
                & vdi_pkg::coord_equal(rd_data_ff[31:0],  item_ff.pos_z_bits);

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vdi_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      item_ff  <= item_in;
      scan_ff  <= scan_in;
      hit_ff   <= hit_in;
      found_ff <= found_in;
      out_ff   <= out_in;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      count_in = count_ff;
      scan_in  = scan_ff;
      hit_in   = hit_ff;
      found_in = found_ff;
      out_in   = out_ff;
      rd_addr  = scan_ff[AW-1:0];
      wr_en    = 1'b0;
      req.ready = (state_ff == vdi_pkg::ST_IDLE);
      rsp.valid = (state_ff == vdi_pkg::ST_OUTPUT);
      rsp.data  = out_ff;
      case (state_ff)
         vdi_pkg::ST_IDLE: begin
            if (req.valid) begin
               item_in  = req.data;
               scan_in  = '0;
               found_in = 1'b0;
               hit_in   = '0;
               if (req.data.mesh_start) begin
                  count_in = '0;
               end
               state_in = vdi_pkg::ST_READ;
            end
         end
         vdi_pkg::ST_READ: begin
            // issue reads while entries remain
            if (scan_ff < count_ff) begin
               scan_in  = scan_ff + 1'b1;
               state_in = vdi_pkg::ST_COMPARE;
            end else begin
               state_in = vdi_pkg::ST_DECIDE;
            end
         end
         vdi_pkg::ST_COMPARE: begin
            // compare last read, issue next read in same cycle
            if (match) begin
               found_in = 1'b1;
               hit_in   = cmp_addr_ff;
            end
            if (scan_ff < count_ff) begin
               scan_in = scan_ff + 1'b1;
            end else begin
               state_in = vdi_pkg::ST_DECIDE;
            end
         end
         vdi_pkg::ST_DECIDE: begin
            if (found_ff) begin
               out_in = '{vertex_index: vdi_pkg::IndexWidth'(hit_ff),
                          was_new: 1'b0, table_full: 1'b0};
            end else if (count_ff < CW'(vdi_pkg::TableDepth)) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               out_in   = '{vertex_index: vdi_pkg::IndexWidth'(count_ff),
                            was_new: 1'b1, table_full: 1'b0};
            end else begin
               out_in = '{vertex_index: '0, was_new: 1'b0, table_full: 1'b1};
            end
            state_in = vdi_pkg::ST_OUTPUT;
         end
         vdi_pkg::ST_OUTPUT: begin
            if (rsp.ready) begin
               state_in = vdi_pkg::ST_IDLE;
            end
         end
         default: state_in = vdi_pkg::ST_IDLE;
      endcase
   end

   // checks
   `VDI_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(vdi_pkg::TableDepth))
   `VDI_ASSERT_IMPL(a_flags_excl, clock, reset, rsp.valid, !(rsp.data.was_new && rsp.data.table_full))
   `VDI_ASSERT_NEXT(a_new_grows, clock, reset, state_ff == vdi_pkg::ST_DECIDE && wr_en, count_ff == $past(count_ff) + 1'b1)
   `VDI_ASSERT_IMPL(a_full_count, clock, reset, rsp.valid && rsp.data.table_full, count_ff == CW'(vdi_pkg::TableDepth))
endmodule

// ===== sim/testbench.sv =====
// testbench for the vertex dedup indexer: directed and random vertices, scoreboarded indices
`timescale 1ns / 100ps

module testbench;
   logic clock;
   logic reset;

   vdi_req_if req_ch ();
   vdi_rsp_if rsp_ch ();

   vertex_dedup_indexer_core uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // stimulus and expected results
   vdi_pkg::req_type vertex_queue[$];
   vdi_pkg::rsp_type index_queue[$];

   // predictor state: stored positions and fill count
   logic [vdi_pkg::CoordWidth-1:0] stored_x[vdi_pkg::TableDepth];
   logic [vdi_pkg::CoordWidth-1:0] stored_y[vdi_pkg::TableDepth];
   logic [vdi_pkg::CoordWidth-1:0] stored_z[vdi_pkg::TableDepth];
   int unsigned                    stored_count;

   int unsigned failures;
   int unsigned send_idle;
   int unsigned take_idle;
   bit          calm;

   // clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic bit is_nan_bits(logic [31:0] b);
      return b[30:0] > 31'h7F80_0000;
   endfunction

   // float equality: zeros of either sign match, nan matches nothing
   function automatic bit coords_match(logic [31:0] a, logic [31:0] b);
      if (is_nan_bits(a) || is_nan_bits(b)) return 1'b0;
      if ((a[30:0] | b[30:0]) == 31'h0) return 1'b1;
      return a == b;
   endfunction

   // look up or append one vertex, return the expected result beat
   function automatic vdi_pkg::rsp_type index_vertex(vdi_pkg::req_type v);
      vdi_pkg::rsp_type r;
      bit               found;
      int               hit;
      found = 1'b0;
      hit   = 0;
      if (v.mesh_start) stored_count = 0;
      for (int i = 0; i < stored_count; i++) begin
         if (coords_match(stored_x[i], v.pos_x_bits) && coords_match(stored_y[i], v.pos_y_bits)
             && coords_match(stored_z[i], v.pos_z_bits)) begin
            found = 1'b1;
            hit   = i;
         end
      end
      r = '0;
      if (found) begin
         r.vertex_index = hit[7:0];
      end else if (stored_count < vdi_pkg::TableDepth) begin
         stored_x[stored_count] = v.pos_x_bits;
         stored_y[stored_count] = v.pos_y_bits;
         stored_z[stored_count] = v.pos_z_bits;
         r.vertex_index = stored_count[7:0];
         r.was_new      = 1'b1;
         stored_count++;
      end else begin
         r.table_full = 1'b1;
      end
      return r;
   endfunction

   // mostly short gaps, a few long, none while calm
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (calm) return 0;
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // fresh coordinate, biased toward zeros, nans and infinities
   function automatic logic [31:0] fresh_coord();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) return {1'($urandom_range(1)), 31'h0};
      if (roll < 13)
         return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(32'h7F_FFFF, 1))};
      if (roll < 17) return {1'($urandom_range(1)), 31'h7F80_0000};
      return $urandom;
   endfunction

   // coordinate drawn from an earlier one, zeros sometimes with the other sign
   function automatic logic [31:0] reuse_coord(logic [31:0] c);
      if (c[30:0] == 31'h0 && $urandom_range(1)) return {~c[31], c[30:0]};
      return c;
   endfunction

   task automatic add_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit ms);
      vdi_pkg::req_type v;
      v.pos_x_bits = x;
      v.pos_y_bits = y;
      v.pos_z_bits = z;
      v.mesh_start = ms;
      vertex_queue.insert(vertex_queue.size(), v);
   endtask

   // one mesh: a pool of positions, vertices reused from it or fresh
   task automatic add_mesh(int unsigned uniques, int unsigned tail);
      vdi_pkg::req_type pool[$];
      vdi_pkg::req_type v;
      int unsigned total;
      total = uniques + tail;
      for (int i = 0; i < total; i++) begin
         if (i >= uniques || (pool.size() > 0 && $urandom_range(99) < 55)) begin
            v = pool[$urandom_range(pool.size() - 1)];
            v.pos_x_bits = reuse_coord(v.pos_x_bits);
            v.pos_y_bits = reuse_coord(v.pos_y_bits);
            v.pos_z_bits = reuse_coord(v.pos_z_bits);
         end else begin
            v.pos_x_bits = fresh_coord();
            v.pos_y_bits = fresh_coord();
            v.pos_z_bits = fresh_coord();
            pool.insert(pool.size(), v);
         end
         v.mesh_start = (i == 0);
         vertex_queue.insert(vertex_queue.size(), v);
      end
   endtask

   // driver: hold each beat until taken, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data  <= '0;
         send_idle    = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) index_queue.insert(index_queue.size(), index_vertex(req_ch.data));
         if ($urandom_range(63) == 0) calm = ~calm;
         if (send_idle > 0) begin
            send_idle--;
            req_ch.valid <= 1'b0;
         end else if (vertex_queue.size() > 0) begin
            req_ch.data  <= vertex_queue.pop_front();
            req_ch.valid <= 1'b1;
            send_idle = pick_gap();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor: random back-pressure, compare each result beat
   always @(posedge clock) begin
      vdi_pkg::rsp_type want;
      vdi_pkg::rsp_type got;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_idle    = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (index_queue.size() == 0) begin
               $error("result beat with nothing expected: index %0d", got.vertex_index);
               failures++;
            end else begin
               want = index_queue.pop_front();
               if (got.vertex_index !== want.vertex_index) begin
                  $error("vertex_index: expected %0d, got %0d", want.vertex_index,
                         got.vertex_index);
                  failures++;
               end
               if (got.was_new !== want.was_new) begin
                  $error("was_new: expected %0b, got %0b", want.was_new, got.was_new);
                  failures++;
               end
               if (got.table_full !== want.table_full) begin
                  $error("table_full: expected %0b, got %0b", want.table_full, got.table_full);
                  failures++;
               end
            end
            take_idle = pick_gap();
         end
         if (take_idle > 0) begin
            take_idle--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      int unsigned target;
      int unsigned mesh_no;
      failures     = 0;
      stored_count = 0;
      calm         = 1'b0;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;

      // directed: zeros of both signs, nans, infinities, extremes, mesh restart
      add_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
      add_vertex(32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0);
      add_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      add_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      add_vertex(32'h7F80_0001, 32'h0000_0000, 32'h0000_0000, 1'b0);
      add_vertex(32'h7F80_0000, 32'hFF80_0000, 32'h3F80_0000, 1'b0);
      add_vertex(32'h7F80_0000, 32'hFF80_0000, 32'h3F80_0000, 1'b0);
      add_vertex(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 1'b0);
      add_vertex(32'h8000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0);
      add_vertex(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 1'b0);
      add_vertex(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 1'b0);
      add_vertex(32'hFFC0_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      add_vertex(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 1'b1);
      add_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      add_vertex(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 1'b0);
      add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);

      // random meshes; a few overflow the table and then keep hitting or failing
      target  = vertex_queue.size() + 1650;
      mesh_no = 0;
      while (vertex_queue.size() < target) begin
         if (mesh_no == 2 || $urandom_range(15) == 0)
            add_mesh($urandom_range(300, 258), $urandom_range(40, 20));
         else
            add_mesh($urandom_range(40, 1), 3 * $urandom_range(20, 1));
         mesh_no++;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      wait (vertex_queue.size() == 0 && !req_ch.valid);
      wait (index_queue.size() == 0);
      repeat (300) @(posedge clock);
      if (failures == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
